[rtl/core/epa_pkg.sv]
// ----------------------------------------------------------------------------
// epa_pkg
// Shared types, constants and modular helpers for the elliptic point adder.
// ----------------------------------------------------------------------------
package epa_pkg;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned CNT_W      = $clog2(FIELD_BITS);
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [FIELD_BITS-1:0] MODULUS_RST = FIELD_BITS'(31);
  localparam logic [FIELD_BITS-1:0] COEFF_A_RST = FIELD_BITS'(2);

  // Result status codes.
  localparam logic [1:0] ST_FINITE   = 2'd0;
  localparam logic [1:0] ST_INFINITY = 2'd1;
  localparam logic [1:0] ST_NOINV    = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  typedef struct packed {
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [31:0] second_x;
    logic [31:0] second_y;
  } point_pair_t;

  typedef struct packed {
    logic [31:0] sum_x;
    logic [31:0] sum_y;
    logic [1:0]  add_status;
  } point_sum_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHORD,
    OP_START_RED,
    OP_SAVE_A,
    OP_START_SQ,
    OP_TRIPLE1,
    OP_TRIPLE2,
    OP_ADD_A,
    OP_INV_INIT,
    OP_START_DIV,
    OP_START_QT,
    OP_INV_STEP,
    OP_START_LAM,
    OP_LAM_SAVE,
    OP_START_LL,
    OP_X3_A,
    OP_X3_B,
    OP_T_CALC,
    OP_START_LY,
    OP_Y3,
    OP_FIN
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_CHORD,
    S_RED_S,
    S_RED_W,
    S_SQ_S,
    S_SQ_W,
    S_TRI2,
    S_ADDA,
    S_INV_INIT,
    S_INV_TEST,
    S_DIV_W,
    S_QT_W,
    S_LAM_S,
    S_LAM_W,
    S_LL_S,
    S_LL_W,
    S_X3B,
    S_TCALC,
    S_LY_S,
    S_LY_W,
    S_FIN_OK,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic range_bad;
    logic is_neg;
    logic is_equal;
    logic unit_run;
    logic r1_zero;
    logic r0_one;
  } dp_status_t;

  // (a + b) mod p for b < p and a < p, written as in the arithmetic spec.
  function automatic logic [FIELD_BITS-1:0] mod_add(input logic [FIELD_BITS-1:0] a,
                                                    input logic [FIELD_BITS-1:0] b,
                                                    input logic [FIELD_BITS-1:0] p);
    logic [FIELD_BITS:0] room;
    logic [FIELD_BITS:0] s;
    room = {1'b0, p} - {1'b0, b};
    if ({1'b0, a} >= room) begin
      s = {1'b0, a} - room;
    end else begin
      s = {1'b0, a} + {1'b0, b};
    end
    return s[FIELD_BITS-1:0];
  endfunction

  // (a - b) mod p for a, b < p.
  function automatic logic [FIELD_BITS-1:0] mod_sub(input logic [FIELD_BITS-1:0] a,
                                                    input logic [FIELD_BITS-1:0] b,
                                                    input logic [FIELD_BITS-1:0] p);
    logic [FIELD_BITS-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + (p - b);
    end
    return r;
  endfunction

endpackage

[rtl/core/epa_dp.sv]
// ----------------------------------------------------------------------------
// epa_dp
// Datapath: operand and configuration registers, a bit-serial modular
// multiplier and a restoring divider sharing one step counter.
// ----------------------------------------------------------------------------
module epa_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [epa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [epa_pkg::FIELD_BITS-1:0]     cfg_wdata_i,
  input  epa_pkg::point_pair_t               op_i,
  input  epa_pkg::cmd_t                      cmd_i,
  output epa_pkg::dp_status_t                sts_o,
  output epa_pkg::point_sum_t                res_o
);
  import epa_pkg::*;

  localparam int unsigned W = FIELD_BITS;

  logic [W-1:0] mod_cfg_q, coa_cfg_q;
  logic [W-1:0] p_q, x1_q, y1_q, x2_q, y2_q;
  logic [W-1:0] car_q, num_q, den_q, x3_q, y3_q;
  logic [W-1:0] r0_q, r1_q, t0_q, t1_q;
  logic [W-1:0] ma_q, mb_q, acc_q, dq_q, rem_q;
  logic         run_q, div_q;
  logic [CNT_W-1:0] cnt_q;
  point_sum_t   res_q;

  logic [W-1:0] dbl, acc_step, qm;
  logic [W:0]   rem_sh;
  logic         ge;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_cfg_q <= MODULUS_RST;
      coa_cfg_q <= COEFF_A_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MODULUS) begin
        mod_cfg_q <= cfg_wdata_i;
      end else begin
        coa_cfg_q <= cfg_wdata_i;
      end
    end
  end

  // One step of the serial units.
  always_comb begin
    dbl      = mod_add(acc_q, acc_q, p_q);
    acc_step = mb_q[W-1] ? mod_add(dbl, ma_q, p_q) : dbl;
    rem_sh   = {rem_q, dq_q[W-1]};
    ge       = (rem_sh >= {1'b0, r1_q});
    qm       = (dq_q == p_q) ? '0 : dq_q;
  end

  // Step counter and run flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      div_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_START_RED, OP_START_SQ, OP_START_QT, OP_START_LAM, OP_START_LL,
        OP_START_LY: begin
          run_q <= 1'b1;
          div_q <= 1'b0;
          cnt_q <= CNT_W'(W - 1);
        end
        OP_START_DIV: begin
          run_q <= 1'b1;
          div_q <= 1'b1;
          cnt_q <= CNT_W'(W - 1);
        end
        default: begin
          if (run_q) begin
            cnt_q <= cnt_q - 1'b1;
            if (cnt_q == '0) begin
              run_q <= 1'b0;
            end
          end
        end
      endcase
    end
  end

  // Serial unit operands.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START_RED: begin ma_q <= W'(1); mb_q <= coa_cfg_q; acc_q <= '0; end
      OP_START_SQ:  begin ma_q <= x1_q;  mb_q <= x1_q;      acc_q <= '0; end
      OP_START_QT:  begin ma_q <= qm;    mb_q <= t1_q;      acc_q <= '0; end
      OP_START_LAM: begin ma_q <= num_q; mb_q <= t0_q;      acc_q <= '0; end
      OP_START_LL:  begin ma_q <= num_q; mb_q <= num_q;     acc_q <= '0; end
      OP_START_LY:  begin ma_q <= num_q; mb_q <= car_q;     acc_q <= '0; end
      OP_START_DIV: begin dq_q <= r0_q;  rem_q <= '0; end
      default: begin
        if (run_q && !div_q) begin
          acc_q <= acc_step;
          mb_q  <= {mb_q[W-2:0], 1'b0};
        end
        if (run_q && div_q) begin
          rem_q <= ge ? W'(rem_sh - {1'b0, r1_q}) : rem_sh[W-1:0];
          dq_q  <= {dq_q[W-2:0], ge};
        end
      end
    endcase
  end

  // Field registers written by the non-serial operations.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        p_q  <= mod_cfg_q;
        x1_q <= op_i.first_x;
        y1_q <= op_i.first_y;
        x2_q <= op_i.second_x;
        y2_q <= op_i.second_y;
      end
      OP_CHORD: begin
        num_q <= mod_sub(y2_q, y1_q, p_q);
        den_q <= mod_sub(x2_q, x1_q, p_q);
      end
      OP_SAVE_A:  car_q <= acc_q;
      OP_TRIPLE1: num_q <= mod_add(acc_q, acc_q, p_q);
      OP_TRIPLE2: num_q <= mod_add(num_q, acc_q, p_q);
      OP_ADD_A: begin
        num_q <= mod_add(num_q, car_q, p_q);
        den_q <= mod_add(y1_q, y1_q, p_q);
      end
      OP_INV_INIT: begin
        r0_q <= p_q;
        r1_q <= den_q;
        t0_q <= '0;
        t1_q <= W'(1);
      end
      OP_INV_STEP: begin
        r0_q <= r1_q;
        r1_q <= rem_q;
        t0_q <= t1_q;
        t1_q <= mod_sub(t0_q, acc_q, p_q);
      end
      OP_LAM_SAVE: num_q <= acc_q;
      OP_X3_A:     x3_q  <= mod_sub(acc_q, x1_q, p_q);
      OP_X3_B:     x3_q  <= mod_sub(x3_q, x2_q, p_q);
      OP_T_CALC:   car_q <= mod_sub(x1_q, x3_q, p_q);
      OP_Y3:       y3_q  <= mod_sub(acc_q, y1_q, p_q);
      OP_FIN: begin
        res_q.add_status <= cmd_i.status;
        res_q.sum_x      <= (cmd_i.status == ST_FINITE) ? x3_q : '0;
        res_q.sum_y      <= (cmd_i.status == ST_FINITE) ? y3_q : '0;
      end
      default: ;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    sts_o.range_bad = (p_q < W'(3)) || (x1_q >= p_q) || (y1_q >= p_q) ||
                      (x2_q >= p_q) || (y2_q >= p_q);
    sts_o.is_equal  = (x1_q == x2_q) && (y1_q == y2_q);
    sts_o.is_neg    = (x1_q == x2_q) && (y1_q == mod_sub('0, y2_q, p_q));
    sts_o.unit_run  = run_q;
    sts_o.r1_zero   = (r1_q == '0);
    sts_o.r0_one    = (r0_q == W'(1));
  end

  assign res_o = res_q;

endmodule

[rtl/core/epa_ctrl.sv]
// ----------------------------------------------------------------------------
// epa_ctrl
// Controller: sequences the point addition over the datapath operations.
// ----------------------------------------------------------------------------
module epa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  epa_pkg::dp_status_t  sts_i,
  output epa_pkg::cmd_t        cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import epa_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (start_i) state_d = S_CHECK;
      S_CHECK: begin
        if (sts_i.range_bad || sts_i.is_neg) begin
          state_d = S_DONE;
        end else if (sts_i.is_equal) begin
          state_d = S_RED_S;
        end else begin
          state_d = S_CHORD;
        end
      end
      S_CHORD:    state_d = S_INV_INIT;
      S_RED_S:    state_d = S_RED_W;
      S_RED_W:    if (!sts_i.unit_run) state_d = S_SQ_S;
      S_SQ_S:     state_d = S_SQ_W;
      S_SQ_W:     if (!sts_i.unit_run) state_d = S_TRI2;
      S_TRI2:     state_d = S_ADDA;
      S_ADDA:     state_d = S_INV_INIT;
      S_INV_INIT: state_d = S_INV_TEST;
      S_INV_TEST: begin
        if (!sts_i.r1_zero) begin
          state_d = S_DIV_W;
        end else if (sts_i.r0_one) begin
          state_d = S_LAM_S;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV_W:    if (!sts_i.unit_run) state_d = S_QT_W;
      S_QT_W:     if (!sts_i.unit_run) state_d = S_INV_TEST;
      S_LAM_S:    state_d = S_LAM_W;
      S_LAM_W:    if (!sts_i.unit_run) state_d = S_LL_S;
      S_LL_S:     state_d = S_LL_W;
      S_LL_W:     if (!sts_i.unit_run) state_d = S_X3B;
      S_X3B:      state_d = S_TCALC;
      S_TCALC:    state_d = S_LY_S;
      S_LY_S:     state_d = S_LY_W;
      S_LY_W:     if (!sts_i.unit_run) state_d = S_FIN_OK;
      S_FIN_OK:   state_d = S_DONE;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Commands and strobes.
  always_comb begin
    cmd_o.op     = OP_NONE;
    cmd_o.status = ST_FINITE;
    busy_o       = (state_q != S_IDLE);
    done_o       = (state_q == S_DONE);
    unique case (state_q)
      S_IDLE:     if (start_i) cmd_o.op = OP_LOAD;
      S_CHECK: begin
        if (sts_i.range_bad) begin
          cmd_o.op     = OP_FIN;
          cmd_o.status = ST_RANGE;
        end else if (sts_i.is_neg) begin
          cmd_o.op     = OP_FIN;
          cmd_o.status = ST_INFINITY;
        end
      end
      S_CHORD:    cmd_o.op = OP_CHORD;
      S_RED_S:    cmd_o.op = OP_START_RED;
      S_RED_W:    if (!sts_i.unit_run) cmd_o.op = OP_SAVE_A;
      S_SQ_S:     cmd_o.op = OP_START_SQ;
      S_SQ_W:     if (!sts_i.unit_run) cmd_o.op = OP_TRIPLE1;
      S_TRI2:     cmd_o.op = OP_TRIPLE2;
      S_ADDA:     cmd_o.op = OP_ADD_A;
      S_INV_INIT: cmd_o.op = OP_INV_INIT;
      S_INV_TEST: begin
        if (!sts_i.r1_zero) begin
          cmd_o.op = OP_START_DIV;
        end else if (!sts_i.r0_one) begin
          cmd_o.op     = OP_FIN;
          cmd_o.status = ST_NOINV;
        end
      end
      S_DIV_W:    if (!sts_i.unit_run) cmd_o.op = OP_START_QT;
      S_QT_W:     if (!sts_i.unit_run) cmd_o.op = OP_INV_STEP;
      S_LAM_S:    cmd_o.op = OP_START_LAM;
      S_LAM_W:    if (!sts_i.unit_run) cmd_o.op = OP_LAM_SAVE;
      S_LL_S:     cmd_o.op = OP_START_LL;
      S_LL_W:     if (!sts_i.unit_run) cmd_o.op = OP_X3_A;
      S_X3B:      cmd_o.op = OP_X3_B;
      S_TCALC:    cmd_o.op = OP_T_CALC;
      S_LY_S:     cmd_o.op = OP_START_LY;
      S_LY_W:     if (!sts_i.unit_run) cmd_o.op = OP_Y3;
      S_FIN_OK: begin
        cmd_o.op     = OP_FIN;
        cmd_o.status = ST_FINITE;
      end
      S_DONE:     cmd_o.op = OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  // An accepted request always leads to the operand check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_CHECK))
    else $error("accepted request did not reach the check state");

  // The result strobe is one cycle wide and frees the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("result strobe not followed by idle");

  // A result is only reported after the result register was written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> ($past(cmd_o.op) == OP_FIN))
    else $error("result strobe without a final write");

endmodule

[rtl/core/elliptic_point_add_core.sv]
// ----------------------------------------------------------------------------
// elliptic_point_add_core
// Affine point addition over a prime field with a serial multiplier and an
// iterative Euclidean inverse.
// ----------------------------------------------------------------------------
//  Channel   Ports                                    Handshake
//  request   start, busy, op_i                        start && !busy
//  result    done_o, res_o                            done_o, one cycle
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i         cfg_we_i
//
// Out-of-range and infinity cases go from the check state straight to the
// result strobe. A finite sum first runs the Euclidean inverse (at most about
// 46 steps for 32 bits); each step is a serial division and then a serial
// multiplication by the quotient, each started and then waited on in turn.
// Doubling first adds a reduction of the coefficient a and a squaring. Reset
// clears the controller and loads the configuration register reset values.
// The result strobe cannot be held off; a new request is taken after it.
// ----------------------------------------------------------------------------
module elliptic_point_add_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  epa_pkg::point_pair_t               op_i,
  output logic                               done_o,
  output epa_pkg::point_sum_t                res_o,
  input  logic                               cfg_we_i,
  input  logic [epa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [epa_pkg::FIELD_BITS-1:0]     cfg_wdata_i
);
  import epa_pkg::*;

  cmd_t       cmd;
  dp_status_t sts;

  // Sequencer.
  epa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Arithmetic.
  epa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o)
  );

endmodule
